// ===== src/bdll_pkg.sv =====
// ----------------------------------------------------------------------------
// bdll_pkg
// shared types and codes for the bounded doubly linked list
// ----------------------------------------------------------------------------
package bdll_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int QDEPTH = 2;

  typedef enum logic [3:0] {
    ACT_PUSH_FRONT = 4'd0,
    ACT_PUSH_BACK  = 4'd1,
    ACT_INSERT_AT  = 4'd2,
    ACT_POP_FRONT  = 4'd3,
    ACT_POP_BACK   = 4'd4,
    ACT_REMOVE_AT  = 4'd5,
    ACT_FIND       = 4'd6,
    ACT_CLEAR      = 4'd7,
    ACT_REVERSE    = 4'd8,
    ACT_LIST_ALL   = 4'd9
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_POS_SMALL = 3'd2,
    ST_POS_RANGE = 3'd3,
    ST_APPENDED  = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_FULL      = 3'd6
  } status_t;

  // operation codes the back end executes
  typedef enum logic [3:0] {
    OP_REPLY,      // single result, no change
    OP_LINK_FRONT,
    OP_LINK_BACK,
    OP_LINK_AT,    // walk to position then link before it
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_REMOVE_AT,
    OP_FIND,
    OP_CLEAR,
    OP_REVERSE,
    OP_LIST
  } op_t;

  typedef struct packed {
    op_t         op;
    status_t     status;
    logic [31:0] value;
    logic [7:0]  position;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_LINK,
    S_UNLINK,
    S_SCAN,
    S_REV,
    S_CLEAR,
    S_EMIT
  } bstate_t;

endpackage

// ===== src/bounded_doubly_linked_list_top.sv =====
// ----------------------------------------------------------------------------
// bounded_doubly_linked_list_top
// bounded doubly linked list of signed 32-bit values
// ----------------------------------------------------------------------------
// One request is handled at a time: a request is taken only when the back end
// is idle and its last result has been taken. Insert at and remove at walk the
// links one entry per cycle to the position, list all, find and reverse step
// through the values, and clear sweeps all CAPACITY link entries. A receiver
// that holds off a result also holds off the next request.
module bounded_doubly_linked_list_top #(
  parameter int CAPACITY = bdll_pkg::DEF_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  action,
  input  logic [31:0] value,
  input  logic [7:0]  position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] item_value,
  output logic [6:0]  found_position,
  output logic [6:0]  entry_count,
  output logic        is_empty,
  output logic        last
);
  import bdll_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  // request queue between classifier and executor
  cmd_t          cmd;
  logic          cmd_valid, cmd_ready, back_idle;
  logic [CW-1:0] held_count;

  bdll_front #(.CAPACITY(CAPACITY), .CW(CW)) u_front (
    .clk, .rst, .in_valid, .in_ready, .action, .value, .position,
    .held_count, .back_idle, .cmd_valid, .cmd_ready, .cmd
  );

  bdll_back #(.CAPACITY(CAPACITY), .CW(CW)) u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd, .held_count, .idle(back_idle),
    .out_valid, .out_ready, .status, .item_value, .found_position,
    .entry_count, .is_empty, .last
  );

  // count never exceeds capacity
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    held_count <= CW'(CAPACITY)) else $error("count overflow");
  // empty flag tracks count
  a_emp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (entry_count == 7'd0))) else $error("empty flag");
  // no request accepted while a result is pending
  a_one: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !out_valid) else $error("overlap");
endmodule

// ===== src/bdll_front.sv =====
// ----------------------------------------------------------------------------
// bdll_front
// accepts requests, classifies them against the count and queues commands
// ----------------------------------------------------------------------------
module bdll_front #(
  parameter int CAPACITY = bdll_pkg::DEF_CAPACITY,
  parameter int CW = $clog2(CAPACITY + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [3:0]       action,
  input  logic [31:0]      value,
  input  logic [7:0]       position,
  input  logic [CW-1:0]    held_count,
  input  logic             back_idle,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output bdll_pkg::cmd_t   cmd
);
  import bdll_pkg::*;

  // one request at a time: the count used for classification must be settled
  logic  busy;
  cmd_t  q [QDEPTH];
  logic [1:0] q_cnt;
  logic  q_wr;
  cmd_t  c;
  logic  full_l, empty_l;
  logic [8:0] cnt9;

  assign in_ready  = !busy && (q_cnt == 2'd0) && back_idle;
  assign q_wr      = in_valid && in_ready;
  assign cmd_valid = (q_cnt != 2'd0);
  assign cmd       = q[0];
  assign cnt9      = 9'(held_count);
  assign full_l    = (cnt9 >= 9'(CAPACITY));
  assign empty_l   = (held_count == '0);

  always_comb begin
    c.value    = value;
    c.position = position;
    c.status   = ST_OK;
    c.op       = OP_REPLY;
    unique case (action)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (full_l) c.status = ST_FULL;
        else c.op = (action == ACT_PUSH_FRONT) ? OP_LINK_FRONT : OP_LINK_BACK;
      end
      ACT_INSERT_AT: begin
        if (position == 8'd0) c.status = ST_POS_SMALL;
        else if (full_l) c.status = ST_FULL;
        else if ({1'b0, position} > cnt9) begin
          c.op = OP_LINK_BACK; c.status = ST_APPENDED;
        end else if (position == 8'd1) c.op = OP_LINK_FRONT;
        else c.op = OP_LINK_AT;
      end
      ACT_POP_FRONT, ACT_POP_BACK, ACT_REMOVE_AT, ACT_FIND, ACT_CLEAR,
      ACT_REVERSE, ACT_LIST_ALL: begin
        if (empty_l) c.status = ST_EMPTY;
        else begin
          unique case (action)
            ACT_POP_FRONT: c.op = OP_POP_FRONT;
            ACT_POP_BACK:  c.op = OP_POP_BACK;
            ACT_REMOVE_AT: begin
              if (position == 8'd0 || {1'b0, position} > cnt9) c.status = ST_POS_RANGE;
              else c.op = OP_REMOVE_AT;
            end
            ACT_FIND:    c.op = OP_FIND;
            ACT_CLEAR:   c.op = OP_CLEAR;
            ACT_REVERSE: c.op = OP_REVERSE;
            default:     c.op = OP_LIST;
          endcase
        end
      end
      default: c.op = OP_REPLY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= 2'd0;
      busy  <= 1'b0;
    end else begin
      if (q_wr) begin
        q[0]  <= c;
        q_cnt <= 2'd1;
        busy  <= 1'b1;
      end else if (cmd_valid && cmd_ready) begin
        q_cnt <= 2'd0;
      end
      if (busy && q_cnt == 2'd0 && !q_wr) busy <= 1'b0;
    end
  end
endmodule

// ===== src/bdll_back.sv =====
// ----------------------------------------------------------------------------
// bdll_back
// executes list commands over the link stores and emits results
// ----------------------------------------------------------------------------
module bdll_back #(
  parameter int CAPACITY = bdll_pkg::DEF_CAPACITY,
  parameter int CW = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  bdll_pkg::cmd_t      cmd,
  output logic [CW-1:0]       held_count,
  output logic                idle,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          status,
  output logic [31:0]         item_value,
  output logic [6:0]          found_position,
  output logic [6:0]          entry_count,
  output logic                is_empty,
  output logic                last
);
  import bdll_pkg::*;

  localparam int IW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] NIL = IW'(CAPACITY);

  logic [31:0]   vals  [CAPACITY];
  logic [IW-1:0] nxt   [CAPACITY];
  logic [IW-1:0] prv   [CAPACITY];
  logic [IW-1:0] head, tail, free_h;
  bstate_t       state, state_next;
  cmd_t          cur;
  logic [IW-1:0] e;          // walking entry
  logic [7:0]    pos;        // walk position, 1-based
  logic          any_hit;
  logic [6:0]    hit_pos;    // latest find hit, held back until the next one or the end
  logic [IW-1:0] clr_i;

  logic [$clog2(CAPACITY)-1:0] ei, pi, ni, fi;
  logic [IW-1:0] pe, ne;
  assign ei = e[$clog2(CAPACITY)-1:0];
  assign fi = free_h[$clog2(CAPACITY)-1:0];
  assign pe = prv[ei];
  assign ne = nxt[ei];
  assign pi = pe[$clog2(CAPACITY)-1:0];
  assign ni = ne[$clog2(CAPACITY)-1:0];

  assign idle      = (state == S_IDLE) && !out_valid;
  assign cmd_ready = (state == S_IDLE) && !out_valid;
  assign entry_count = 7'(held_count);
  assign is_empty    = (held_count == '0);

  logic out_free;
  assign out_free = !out_valid || out_ready;

  logic hit, scan_end, out_load;
  assign hit      = (vals[ei] == cur.value);
  assign scan_end = (ne == NIL);
  assign out_load = out_free &&
                    (((state == S_SCAN) && ((cur.op == OP_LIST) || (hit && any_hit))) ||
                     (state == S_EMIT));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (cmd_valid && cmd_ready) begin
        unique case (cmd.op)
          OP_LINK_FRONT, OP_LINK_BACK: state_next = S_LINK;
          OP_LINK_AT, OP_REMOVE_AT: state_next = S_WALK;
          OP_POP_FRONT, OP_POP_BACK: state_next = S_UNLINK;
          OP_FIND, OP_LIST: state_next = S_SCAN;
          OP_REVERSE: state_next = S_REV;
          OP_CLEAR: state_next = S_CLEAR;
          default: state_next = S_EMIT;
        endcase
      end
      S_WALK: if (pos == cur.position)
        state_next = (cur.op == OP_LINK_AT) ? S_LINK : S_UNLINK;
      S_LINK, S_UNLINK: state_next = S_EMIT;
      S_SCAN: if (out_free && scan_end)
        state_next = (cur.op == OP_FIND) ? S_EMIT : S_IDLE;
      S_REV: if (ne == NIL) state_next = S_EMIT;
      S_CLEAR: if (clr_i == IW'(CAPACITY - 1)) state_next = S_EMIT;
      S_EMIT: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      head <= NIL; tail <= NIL; free_h <= '0; held_count <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        nxt[i] <= IW'(i + 1);
        prv[i] <= NIL;
      end
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (cmd_valid && cmd_ready) begin
          cur <= cmd; pos <= 8'd1; any_hit <= 1'b0; hit_pos <= '0; clr_i <= '0;
          unique case (cmd.op)
            OP_POP_BACK: e <= tail;
            default:     e <= head;
          endcase
        end
        S_WALK: if (pos != cur.position) begin
          e <= ne; pos <= pos + 8'd1;
        end
        S_LINK: begin
          vals[fi] <= cur.value;
          free_h <= nxt[fi];
          held_count <= held_count + 1'b1;
          unique case (cur.op)
            OP_LINK_FRONT: begin
              prv[fi] <= NIL; nxt[fi] <= head;
              if (head == NIL) tail <= free_h;
              else prv[head[$clog2(CAPACITY)-1:0]] <= free_h;
              head <= free_h;
            end
            OP_LINK_BACK: begin
              nxt[fi] <= NIL; prv[fi] <= tail;
              if (tail == NIL) head <= free_h;
              else nxt[tail[$clog2(CAPACITY)-1:0]] <= free_h;
              tail <= free_h;
            end
            default: begin  // before e, which is not the head
              prv[fi] <= pe; nxt[fi] <= e;
              nxt[pi] <= free_h; prv[ei] <= free_h;
            end
          endcase
        end
        S_UNLINK: begin
          if (pe == NIL) head <= ne; else nxt[pi] <= ne;
          if (ne == NIL) tail <= pe; else prv[ni] <= pe;
          nxt[ei] <= free_h; prv[ei] <= NIL; free_h <= e;
          held_count <= held_count - 1'b1;
        end
        S_SCAN: if (out_free) begin
          if (cur.op == OP_LIST) begin
            status <= ST_OK; item_value <= vals[ei];
            found_position <= '0; last <= scan_end;
          end else begin
            // a hit goes out once the next hit shows it was not the final one
            if (hit) begin
              if (any_hit) begin
                status <= ST_OK; item_value <= '0;
                found_position <= hit_pos; last <= 1'b0;
              end
              hit_pos <= 7'(pos); any_hit <= 1'b1;
            end
            if (scan_end) cur.status <= (hit || any_hit) ? ST_OK : ST_NOT_FOUND;
          end
          e <= ne; pos <= pos + 8'd1;
        end
        S_REV: begin
          nxt[ei] <= pe; prv[ei] <= ne; e <= ne;
          if (ne == NIL) begin head <= tail; tail <= head; end
        end
        S_CLEAR: begin
          nxt[clr_i[$clog2(CAPACITY)-1:0]] <= clr_i + 1'b1;
          prv[clr_i[$clog2(CAPACITY)-1:0]] <= NIL;
          clr_i <= clr_i + 1'b1;
          if (clr_i == IW'(CAPACITY - 1)) begin
            head <= NIL; tail <= NIL; free_h <= '0; held_count <= '0;
          end
        end
        S_EMIT: if (out_free) begin
          status <= cur.status; item_value <= '0;
          found_position <= hit_pos; last <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== sim/bounded_doubly_linked_list_top_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_doubly_linked_list_top_tb
// checks the list manager request by request against a linked-list predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import bdll_pkg::*;

typedef struct {
  status_t     st;
  logic [31:0] val;
  logic [6:0]  fpos;
  logic [6:0]  cnt;
  logic        emp;
  logic        lst;
} list_reply_t;

class list_scoreboard;
  int          cap;
  logic [31:0] vals[$];   // list contents in order, front first
  list_reply_t pending[$];
  int          errors;
  int          replies_seen;

  function new(int c);
    cap = c;
    errors = 0;
    replies_seen = 0;
  endfunction

  function void add(status_t s, logic [31:0] v, logic [6:0] p, ref list_reply_t tmp[$]);
    list_reply_t r;
    r.st = s;
    r.val = v;
    r.fpos = p;
    r.cnt = 0;
    r.emp = 0;
    r.lst = 0;
    tmp.push_back(r);
  endfunction

  // note an accepted request and queue the replies it should cause
  function void note_request(logic [3:0] act, logic [31:0] v, logic [7:0] pos);
    list_reply_t tmp[$];
    int n;
    n = vals.size();
    if (act > ACT_LIST_ALL) begin
      add(ST_OK, 0, 0, tmp);
    end else if (act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK) begin
      if (n >= cap) add(ST_FULL, 0, 0, tmp);
      else begin
        if (act == ACT_PUSH_FRONT) vals.push_front(v);
        else vals.push_back(v);
        add(ST_OK, 0, 0, tmp);
      end
    end else if (act == ACT_INSERT_AT) begin
      if (pos < 1) add(ST_POS_SMALL, 0, 0, tmp);
      else if (n >= cap) add(ST_FULL, 0, 0, tmp);
      else if (pos > n) begin
        vals.push_back(v);
        add(ST_APPENDED, 0, 0, tmp);
      end else begin
        vals.insert(pos - 1, v);
        add(ST_OK, 0, 0, tmp);
      end
    end else if (n == 0) begin
      add(ST_EMPTY, 0, 0, tmp);
    end else begin
      case (act)
        ACT_POP_FRONT: begin
          void'(vals.pop_front());
          add(ST_OK, 0, 0, tmp);
        end
        ACT_POP_BACK: begin
          void'(vals.pop_back());
          add(ST_OK, 0, 0, tmp);
        end
        ACT_REMOVE_AT: begin
          if (pos < 1 || pos > n) add(ST_POS_RANGE, 0, 0, tmp);
          else begin
            vals.delete(pos - 1);
            add(ST_OK, 0, 0, tmp);
          end
        end
        ACT_FIND: begin
          for (int i = 0; i < n; i++)
            if (vals[i] == v) add(ST_OK, 0, 7'(i + 1), tmp);
          if (tmp.size() == 0) add(ST_NOT_FOUND, 0, 0, tmp);
        end
        ACT_CLEAR: begin
          vals.delete();
          add(ST_OK, 0, 0, tmp);
        end
        ACT_REVERSE: begin
          vals.reverse();
          add(ST_OK, 0, 0, tmp);
        end
        default: begin
          for (int i = 0; i < n; i++) add(ST_OK, vals[i], 0, tmp);
        end
      endcase
    end
    foreach (tmp[i]) begin
      tmp[i].cnt = 7'(vals.size());
      tmp[i].emp = (vals.size() == 0);
      tmp[i].lst = (i == tmp.size() - 1);
      pending.push_back(tmp[i]);
    end
  endfunction

  function void check_reply(list_reply_t got);
    list_reply_t exp;
    replies_seen++;
    if (pending.size() == 0) begin
      $display("%0t: unexpected reply status %0d", $time, got.st);
      errors++;
      return;
    end
    exp = pending.pop_front();
    if (got.st !== exp.st) begin
      $display("%0t: status exp %0d got %0d", $time, exp.st, got.st);
      errors++;
    end
    if (got.val !== exp.val) begin
      $display("%0t: item_value exp %0h got %0h", $time, exp.val, got.val);
      errors++;
    end
    if (got.fpos !== exp.fpos) begin
      $display("%0t: found_position exp %0d got %0d", $time, exp.fpos, got.fpos);
      errors++;
    end
    if (got.cnt !== exp.cnt) begin
      $display("%0t: entry_count exp %0d got %0d", $time, exp.cnt, got.cnt);
      errors++;
    end
    if (got.emp !== exp.emp) begin
      $display("%0t: is_empty exp %0b got %0b", $time, exp.emp, got.emp);
      errors++;
    end
    if (got.lst !== exp.lst) begin
      $display("%0t: last exp %0b got %0b", $time, exp.lst, got.lst);
      errors++;
    end
  endfunction
endclass

module bounded_doubly_linked_list_top_tb;
  localparam int CAP = DEF_CAPACITY;
  localparam int WATCHDOG = 20000;
  localparam int LONG_HOLD = 300;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  action;
  logic [31:0] value;
  logic [7:0]  position;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic [31:0] item_value;
  logic [6:0]  found_position;
  logic [6:0]  entry_count;
  logic        is_empty;
  logic        last;

  list_scoreboard sb;
  int  idle_cycles;
  int  requests_sent;
  bit  long_stall;       // set by the sender, cleared by the receiver after its hold-off

  bounded_doubly_linked_list_top #(.CAPACITY(CAP)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .value(value), .position(position),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .item_value(item_value), .found_position(found_position),
    .entry_count(entry_count), .is_empty(is_empty), .last(last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // present one request and hold it until accepted; valid stays up when the
  // next request follows with no gap
  task automatic send_request(logic [3:0] a, logic [31:0] v, logic [7:0] p);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= a;
    value <= v;
    position <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(a, v, p);
    requests_sent++;
  endtask

  // stop offering and wait until every queued reply has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // values drawn mostly from a small pool so find hits, sometimes full range
  function automatic logic [31:0] pick_value();
    logic [31:0] pool[4] = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff};
    if ($urandom_range(0, 3) == 0) return $urandom();
    if ($urandom_range(0, 1) == 0) return pool[$urandom_range(0, 3)];
    return $urandom_range(1, 6);
  endfunction

  function automatic logic [7:0] pick_pos();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(1, CAP + 2));
  endfunction

  // receiver: random back pressure, plus a long hold-off on request
  initial begin
    int g;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      if (long_stall) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_stall = 1'b0;
      end else begin
        g = gap_len();
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // reply monitor and watchdog
  always @(posedge clk) begin
    list_reply_t got;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.st = status_t'(status);
        got.val = item_value;
        got.fpos = found_position;
        got.cnt = entry_count;
        got.emp = is_empty;
        got.lst = last;
        sb.check_reply(got);
      end
      if ((out_valid && out_ready) || (in_valid && in_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("%0t: watchdog expired, %0d replies pending", $time, sb.pending.size());
        $display("[bounded_doubly_linked_list_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    sb = new(CAP);
    rst = 1'b1;
    in_valid = 1'b0;
    action = '0;
    value = '0;
    position = '0;
    idle_cycles = 0;
    requests_sent = 0;
    long_stall = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty-list cases first
    send_request(ACT_POP_FRONT, 0, 0);
    send_request(ACT_POP_BACK, 0, 0);
    send_request(ACT_REMOVE_AT, 0, 1);
    send_request(ACT_FIND, 0, 0);
    send_request(ACT_CLEAR, 0, 0);
    send_request(ACT_REVERSE, 0, 0);
    send_request(ACT_LIST_ALL, 0, 0);
    send_request(ACT_INSERT_AT, 32'h5, 8'd0);          // position too small
    send_request(ACT_INSERT_AT, 32'h80000000, 8'd255); // append onto empty list
    send_request(ACT_PUSH_FRONT, 32'h7fffffff, 0);
    send_request(ACT_PUSH_BACK, 32'hffffffff, 0);
    send_request(ACT_INSERT_AT, 32'h7fffffff, 8'd2);
    send_request(ACT_INSERT_AT, 32'h1, 8'd1);
    send_request(ACT_FIND, 32'h7fffffff, 0);           // two matches
    send_request(ACT_FIND, 32'h12345678, 0);           // no match
    send_request(ACT_REMOVE_AT, 0, 8'd0);
    send_request(ACT_REMOVE_AT, 0, 8'd200);
    send_request(ACT_REMOVE_AT, 0, 8'd2);
    send_request(ACT_REVERSE, 0, 0);
    send_request(ACT_LIST_ALL, 0, 0);
    send_request(4'd10, 0, 0);
    send_request(4'd15, 32'hffffffff, 8'hff);

    // fill to capacity with the receiver held off long enough to back up
    long_stall = 1'b1;
    for (int i = 0; i < CAP + 2; i++) send_request(ACT_PUSH_BACK, 32'd3, 0);
    send_request(ACT_PUSH_FRONT, 32'd3, 0);
    send_request(ACT_INSERT_AT, 32'd3, 8'd4);
    send_request(ACT_FIND, 32'd3, 0);                  // every entry pushed here matches
    send_request(ACT_LIST_ALL, 0, 0);
    // sender pauses until the block has drained
    drain();
    send_request(ACT_CLEAR, 0, 0);

    // random: weighted so the list grows and shrinks across its whole range
    for (int i = 0; i < 430; i++) begin
      int r;
      logic [3:0] a;
      r = $urandom_range(0, 99);
      if (r < 35) a = 4'($urandom_range(ACT_PUSH_FRONT, ACT_INSERT_AT));
      else if (r < 60) a = 4'($urandom_range(ACT_POP_FRONT, ACT_REMOVE_AT));
      else if (r < 75) a = ACT_FIND;
      else if (r < 85) a = ACT_LIST_ALL;
      else if (r < 92) a = ACT_REVERSE;
      else if (r < 95) a = ACT_CLEAR;
      else a = 4'($urandom_range(0, 15));
      send_request(a, pick_value(), pick_pos());
      if (i == 200) drain();
    end

    drain();
    repeat (4 * CAP + 20) @(posedge clk);
    $display("run covered %0d requests and %0d replies, all actions incl. full and empty",
             requests_sent, sb.replies_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[bounded_doubly_linked_list_top] OK");
    end else begin
      $display("%0d mismatches, %0d replies still pending", sb.errors, sb.pending.size());
      $display("[bounded_doubly_linked_list_top] ERROR");
    end
    $finish;
  end
endmodule
